// ===== hw/rtl/mhtk_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap top-k selector package
// Shared types, status and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package mhtk_pkg;

  localparam int MaxEntriesDefault = 1024;

  localparam int ScoreW = 32;
  localparam int IdW    = 32;
  localparam int CountW = 11;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REPLACE = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_PEEK    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REPLACED = 3'd3,
    ST_POPPED   = 3'd4,
    ST_PEEKED   = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_POP_LAST,
    S_POP_LAST_W,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_DN_WRITE,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_UP_WRITE,
    S_OUT
  } state_t;

  localparam logic [0:0] RegEntryLimit = 1'b0;

endpackage

// ===== hw/rtl/mhtk_if.sv =====
// ----------------------------------------------------------------------------
// Min-heap top-k selector channels
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface mhtk_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] new_score;
  logic [31:0] doc_id;
  modport source (output valid, mode, new_score, doc_id, input ready);
  modport sink (input valid, mode, new_score, doc_id, output ready);
endinterface

interface mhtk_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_score;
  logic [31:0] out_doc_id;
  logic [10:0] entry_count_now;
  modport source (output valid, status, out_score, out_doc_id, entry_count_now,
                  input ready);
  modport sink (input valid, status, out_score, out_doc_id, entry_count_now,
                output ready);
endinterface

// ===== hw/rtl/min_heap_top_k_selector.sv =====
// ----------------------------------------------------------------------------
// Min-heap top-k selector
// Binary min-heap of (score, id) pairs kept in one slot memory.
// ----------------------------------------------------------------------------
// Operations: peek, empty, reject and drop answer without touching the heap order;
//   insert sifts the new entry up level by level; remove head moves the last entry
//   to the top and sifts it down; replace does both.
// Flow: one beat at a time; a request is accepted only after the last result is taken;
//   the single-port slot memory (one read or one write a cycle) sets the per-level cost.
// Reset: rst empties the heap and sets entry_limit to 1024; slots are not cleared.
module min_heap_top_k_selector #(
  parameter int MAX_ENTRIES = mhtk_pkg::MaxEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mhtk_req_if.sink    req,
  mhtk_rsp_if.source  rsp
);
  import mhtk_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES + 1);   // heap positions 1..MAX_ENTRIES
  localparam int NW = AW + 1;                    // room for 2*i
  localparam int MW = ScoreW + IdW;

  // Slot memory: one access a cycle, registered read.
  logic [MW-1:0] mem [0:(1<<AW)-1];
  logic [MW-1:0] rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [MW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  state_t state, state_next;

  logic [CountW-1:0] entry_limit;
  logic [AW:0]       count;          // holds 0..MAX_ENTRIES
  logic [AW:0]       pos;            // current heap position
  logic [AW:0]       child;
  logic [MW-1:0]     item;           // item being sifted
  logic [MW-1:0]     head;           // head read at DECIDE
  logic [MW-1:0]     lchild;
  logic              two_kids, rd_right;
  logic              do_push;        // push pending after pop (replace)
  logic [1:0]        mode_q;
  logic [2:0]        status_q;
  logic [MW-1:0]     out_q;

  // Config port: one register at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegEntryLimit) ? {21'd0, entry_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= CountW'(1024);
    end else if (psel && penable && pwrite && paddr[2] == RegEntryLimit) begin
      entry_limit <= pwdata[CountW-1:0];
    end
  end

  // Effective limit clamped to 1..MAX_ENTRIES.
  logic [AW:0] lim_eff;
  always_comb begin
    if (entry_limit == '0) lim_eff = (AW+1)'(1);
    else if ({21'd0, entry_limit} > 32'(MAX_ENTRIES)) lim_eff = (AW+1)'(MAX_ENTRIES);
    else if (AW + 1 >= CountW) lim_eff = (AW+1)'(entry_limit);
    else lim_eff = (AW+1)'(entry_limit);
  end
  logic full;
  assign full = count >= lim_eff;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.status = status_q;
  assign rsp.out_score = out_q[MW-1:IdW];
  assign rsp.out_doc_id = out_q[IdW-1:0];
  assign rsp.entry_count_now = CountW'(count);

  logic [ScoreW-1:0] rd_score, it_score, lc_score;
  assign rd_score = rd_q[MW-1:IdW];
  assign it_score = item[MW-1:IdW];
  assign lc_score = lchild[MW-1:IdW];
  logic [AW:0] parent;
  assign parent = pos >> 1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (req.valid && req.ready) state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (mode_t'(mode_q))
          MODE_INSERT:  state_next = full ? S_OUT : S_UP_RD;
          MODE_REPLACE: begin
            if (!full) state_next = S_UP_RD;
            else if (count == '0 || rd_score >= it_score) state_next = S_OUT;
            else state_next = S_POP_LAST;
          end
          default:      state_next = (count == '0 || mode_q == MODE_PEEK) ? S_OUT
                                                                        : S_POP_LAST;
        endcase
      end
      S_POP_LAST:   state_next = S_POP_LAST_W;
      S_POP_LAST_W: state_next = S_DN_RD;
      S_DN_RD:      state_next = (pos << 1) > count ? S_DN_WRITE : S_DN_WAIT;
      S_DN_WAIT:    state_next = two_kids ? S_DN_WAIT : S_DN_CMP;
      S_DN_CMP:     state_next = (it_score > lc_score) ? S_DN_RD : S_DN_WRITE;
      S_DN_WRITE:   state_next = do_push ? S_UP_RD : S_OUT;
      S_UP_RD:      state_next = (pos > (AW+1)'(1)) ? S_UP_WAIT : S_UP_WRITE;
      S_UP_WAIT:    state_next = S_UP_CMP;
      S_UP_CMP:     state_next = (rd_score > it_score) ? S_UP_RD : S_UP_WRITE;
      S_UP_WRITE:   state_next = S_OUT;
      S_OUT:        if (rsp.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = '0;
    mem_wd = item;
    unique case (state)
      S_IDLE:     begin mem_re = 1'b1; mem_addr = AW'(1); end
      S_POP_LAST: begin mem_re = 1'b1; mem_addr = AW'(count); end
      S_DN_RD: begin
        if ((pos << 1) <= count) begin
          mem_re = 1'b1; mem_addr = AW'(pos << 1);
        end
      end
      S_DN_WAIT: begin
        if (two_kids) begin mem_re = 1'b1; mem_addr = AW'(child + 1'b1); end
      end
      S_DN_CMP: begin
        if (it_score > lc_score) begin
          mem_we = 1'b1; mem_addr = AW'(pos); mem_wd = lchild;
        end
      end
      S_DN_WRITE: begin mem_we = 1'b1; mem_addr = AW'(pos); end
      S_UP_RD: begin
        if (pos > (AW+1)'(1)) begin mem_re = 1'b1; mem_addr = AW'(parent); end
      end
      S_UP_CMP: begin
        if (rd_score > it_score) begin
          mem_we = 1'b1; mem_addr = AW'(pos); mem_wd = rd_q;
        end
      end
      S_UP_WRITE: begin mem_we = 1'b1; mem_addr = AW'(pos); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      do_push <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_q <= req.mode;
            item <= {req.new_score, req.doc_id};
          end
        end
        S_DECIDE: begin
          head <= rd_q;
          out_q <= '0;
          do_push <= 1'b0;
          case (mode_t'(mode_q))
            MODE_INSERT: begin
              if (full) status_q <= ST_FULL;
              else begin
                status_q <= ST_INSERTED; count <= count + 1'b1; pos <= count + 1'b1;
              end
            end
            MODE_REPLACE: begin
              if (!full) begin
                status_q <= ST_INSERTED; count <= count + 1'b1; pos <= count + 1'b1;
              end else if (count == '0 || rd_score >= it_score) begin
                status_q <= ST_DROPPED;
              end else begin
                status_q <= ST_REPLACED; out_q <= rd_q; do_push <= 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (count == '0) status_q <= ST_EMPTY;
              else begin status_q <= ST_POPPED; out_q <= rd_q; end
            end
            default: begin
              if (count == '0) status_q <= ST_EMPTY;
              else begin status_q <= ST_PEEKED; out_q <= rd_q; end
            end
          endcase
        end
        S_POP_LAST: count <= count - 1'b1;
        S_POP_LAST_W: begin
          // Hold the new item aside in head; sift the last entry down.
          head <= item;
          item <= rd_q;
          pos <= (AW+1)'(1);
        end
        S_DN_RD: begin
          child <= pos << 1;
          two_kids <= ((pos << 1) < count);
          rd_right <= 1'b0;
        end
        S_DN_WAIT: begin
          if (!rd_right) lchild <= rd_q;
          if (two_kids) begin
            two_kids <= 1'b0;
            rd_right <= 1'b1;
          end else if (rd_right) begin
            if (rd_score < lc_score) begin
              lchild <= rd_q; child <= child + 1'b1;
            end
          end
        end
        S_DN_CMP: if (it_score > lc_score) pos <= child;
        S_DN_WRITE: begin
          if (do_push) begin
            item <= head; count <= count + 1'b1; pos <= count + 1'b1;
          end
        end
        S_UP_CMP: if (rd_score > it_score) pos <= parent;
        default: ;
      endcase
    end
  end

  // Right child arrives in the cycle after the left; the second WAIT pass
  // settles it before S_DN_CMP.

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(MAX_ENTRIES))
    else $error("heap count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !rsp.ready) |=> (state == S_OUT && $stable(rsp.status)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst) !(req.ready && rsp.valid))
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && mode_q == MODE_PEEK) |=> $stable(count))
    else $error("peek changed count");
endmodule
